// File: src/usb_bulk_in_double_buffer_packetizer_macros.svh
// ----------------------------------------------------------------------------
// USB bulk IN packetizer assertion macros
// Shared concurrent assertion forms, clocked on clk and held off by arst_n.
// ----------------------------------------------------------------------------
`ifndef USB_BULK_IN_DOUBLE_BUFFER_PACKETIZER_MACROS_SVH
`define USB_BULK_IN_DOUBLE_BUFFER_PACKETIZER_MACROS_SVH

// Same-cycle implication
`define UBP_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("packetizer assertion failed");

// Next-cycle implication
`define UBP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("packetizer assertion failed");

`endif

// File: src/ubp_pkg.sv
// ----------------------------------------------------------------------------
// USB bulk IN packetizer package
// Function codes, result kinds, result word layout and slot positions.
// ----------------------------------------------------------------------------
package ubp_pkg;

	// Input function codes
	typedef enum logic [1:0] {
		FUNC_PUT    = 2'd0,
		FUNC_FLUSH  = 2'd1,
		FUNC_DONE   = 2'd2,
		FUNC_CONFIG = 2'd3
	} func_t;

	// Result kinds
	typedef enum logic [2:0] {
		KIND_WRITE = 3'd0,
		KIND_SENT  = 3'd1,
		KIND_BUSY  = 3'd2,
		KIND_DROP  = 3'd3,
		KIND_ACK   = 3'd4
	} kind_t;

	localparam logic [7:0] CHAR_LF = 8'h0A;
	localparam logic [7:0] CHAR_CR = 8'h0D;

	// One result word
	typedef struct packed {
		kind_t      kind;
		logic       bank;
		logic [6:0] position;
		logic [7:0] out_byte;
	} result_t;

	// Bank control flags
	typedef struct packed {
		logic       cur_bank;
		logic       flushed;
		logic [1:0] pending;
	} flags_t;

	// Fixed result slots, drained lowest first; single DROP, BUSY and ACK results use the first slot
	localparam int NUM_SLOTS     = 5;
	localparam int SLOT_CR_WRITE = 0;
	localparam int SLOT_CR_SEND  = 1;
	localparam int SLOT_CH_WRITE = 2;
	localparam int SLOT_CH_SEND  = 3;
	localparam int SLOT_FLUSH    = 4;

	localparam result_t RESULT_ACK = '{kind: KIND_ACK, bank: 1'b0, position: 7'd0,
		out_byte: 8'd0};
	localparam result_t RESULT_DROP = '{kind: KIND_DROP, bank: 1'b0, position: 7'd0,
		out_byte: 8'd0};

endpackage

// File: src/ubp_ifs.sv
// ----------------------------------------------------------------------------
// USB bulk IN packetizer channels
// Valid/ready interfaces for the input item and result word channels.
// ----------------------------------------------------------------------------
interface ubp_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [7:0] data_byte;
	logic [1:0] done_mask;

	modport source(output valid, output func, output data_byte, output done_mask,
		input ready);
	modport sink(input valid, input func, input data_byte, input done_mask,
		output ready);
endinterface

interface ubp_result_if;
	logic       valid;
	logic       ready;
	logic [2:0] kind;
	logic       bank;
	logic [6:0] position;
	logic [7:0] out_byte;
	logic       last;

	modport source(output valid, output kind, output bank, output position,
		output out_byte, output last, input ready);
	modport sink(input valid, input kind, input bank, input position,
		input out_byte, input last, output ready);
endinterface

// File: src/ubp_step.sv
// ----------------------------------------------------------------------------
// USB bulk IN packetizer step logic
// Computes all result words and the next bank state for one input item.
// ----------------------------------------------------------------------------
module ubp_step #(
	parameter int PACKET_SIZE = 64,
	localparam int FW = $clog2(PACKET_SIZE)
) (
	input  logic                                    link_up,
	input  logic [1:0]                              func,
	input  logic [7:0]                              data_byte,
	input  logic [1:0]                              done_mask,
	input  logic [FW-1:0]                           fill,
	input  ubp_pkg::flags_t                         flags,
	output logic [FW-1:0]                           fill_nxt,
	output ubp_pkg::flags_t                         flags_nxt,
	output logic [ubp_pkg::NUM_SLOTS-1:0]           slot_vld,
	output ubp_pkg::result_t [ubp_pkg::NUM_SLOTS-1:0] slots
);

	localparam logic [FW-1:0] FILL_LAST = FW'(PACKET_SIZE - 1);
	localparam logic [6:0]    FULL_POS  = 7'(PACKET_SIZE % 128);

	function automatic logic [6:0] pos7(input logic [FW-1:0] f);
		logic [FW+6:0] w;
		w = {7'd0, f};
		return w[6:0];
	endfunction

	logic            nl;
	logic            full_a, busy_a, full_b, busy_b, fire_c, busy_c;
	logic [FW-1:0]   f1, f2, fx;
	ubp_pkg::flags_t fl1, fl2, flx, fl3;
	logic            put_ok, busy_bank;
	ubp_pkg::result_t w_a, s_a, w_b, s_b, r_c, r_busy;

	always_comb begin
		nl = data_byte == ubp_pkg::CHAR_LF;

		// Carriage return ahead of a newline
		full_a = fill == FILL_LAST;
		busy_a = flags.pending[flags.cur_bank];
		w_a = '{kind: ubp_pkg::KIND_WRITE, bank: flags.cur_bank, position: pos7(fill),
			out_byte: ubp_pkg::CHAR_CR};
		s_a = '{kind: ubp_pkg::KIND_SENT, bank: flags.cur_bank, position: FULL_POS,
			out_byte: 8'd0};
		if (nl) begin
			fl1.cur_bank = full_a ? ~flags.cur_bank : flags.cur_bank;
			fl1.flushed  = 1'b0;
			fl1.pending  = full_a ? (flags.pending | {flags.cur_bank, ~flags.cur_bank})
				: flags.pending;
			f1 = full_a ? '0 : fill + FW'(1);
		end else begin
			fl1 = flags;
			f1  = fill;
		end

		// The byte itself
		full_b = f1 == FILL_LAST;
		busy_b = fl1.pending[fl1.cur_bank];
		w_b = '{kind: ubp_pkg::KIND_WRITE, bank: fl1.cur_bank, position: pos7(f1),
			out_byte: data_byte};
		s_b = '{kind: ubp_pkg::KIND_SENT, bank: fl1.cur_bank, position: FULL_POS,
			out_byte: 8'd0};
		fl2.cur_bank = full_b ? ~fl1.cur_bank : fl1.cur_bank;
		fl2.flushed  = 1'b0;
		fl2.pending  = full_b ? (fl1.pending | {fl1.cur_bank, ~fl1.cur_bank}) : fl1.pending;
		f2 = full_b ? '0 : f1 + FW'(1);

		// Flush, either requested or following a newline
		if (ubp_pkg::func_t'(func) == ubp_pkg::FUNC_FLUSH) begin
			flx = flags;
			fx  = fill;
		end else begin
			flx = fl2;
			fx  = f2;
		end
		fire_c = ~flx.flushed;
		busy_c = fire_c & flx.pending[flx.cur_bank];
		r_c = '{kind: ubp_pkg::KIND_SENT, bank: flx.cur_bank, position: pos7(fx),
			out_byte: 8'd0};
		fl3.cur_bank = ~flx.cur_bank;
		fl3.flushed  = 1'b1;
		fl3.pending  = flx.pending | {flx.cur_bank, ~flx.cur_bank};

		// Refuse the whole put if any step hits a pending bank
		put_ok = ~(nl & busy_a) & ~busy_b & ~(nl & busy_c);
		if (nl & busy_a) begin
			busy_bank = flags.cur_bank;
		end else if (busy_b) begin
			busy_bank = fl1.cur_bank;
		end else begin
			busy_bank = flx.cur_bank;
		end
		r_busy = '{kind: ubp_pkg::KIND_BUSY, bank: busy_bank, position: 7'd0,
			out_byte: 8'd0};

		// Default slot contents and unchanged state
		slots[ubp_pkg::SLOT_CR_WRITE] = w_a;
		slots[ubp_pkg::SLOT_CR_SEND]  = s_a;
		slots[ubp_pkg::SLOT_CH_WRITE] = w_b;
		slots[ubp_pkg::SLOT_CH_SEND]  = s_b;
		slots[ubp_pkg::SLOT_FLUSH]    = r_c;
		slot_vld  = '0;
		fill_nxt  = fill;
		flags_nxt = flags;

		case (ubp_pkg::func_t'(func))
			ubp_pkg::FUNC_PUT: begin
				if (!link_up) begin
					slots[ubp_pkg::SLOT_CR_WRITE] = ubp_pkg::RESULT_DROP;
					slot_vld[ubp_pkg::SLOT_CR_WRITE] = 1'b1;
				end else if (!put_ok) begin
					slots[ubp_pkg::SLOT_CR_WRITE] = r_busy;
					slot_vld[ubp_pkg::SLOT_CR_WRITE] = 1'b1;
				end else begin
					slot_vld[ubp_pkg::SLOT_CR_WRITE] = nl;
					slot_vld[ubp_pkg::SLOT_CR_SEND]  = nl & full_a;
					slot_vld[ubp_pkg::SLOT_CH_WRITE] = 1'b1;
					slot_vld[ubp_pkg::SLOT_CH_SEND]  = full_b;
					slot_vld[ubp_pkg::SLOT_FLUSH]    = nl & fire_c;
					if (nl & fire_c) begin
						fill_nxt  = '0;
						flags_nxt = fl3;
					end else begin
						fill_nxt  = f2;
						flags_nxt = fl2;
					end
				end
			end
			ubp_pkg::FUNC_FLUSH: begin
				if (!link_up) begin
					slots[ubp_pkg::SLOT_CR_WRITE] = ubp_pkg::RESULT_DROP;
					slot_vld[ubp_pkg::SLOT_CR_WRITE] = 1'b1;
				end else if (busy_c) begin
					slots[ubp_pkg::SLOT_CR_WRITE] = r_busy;
					slot_vld[ubp_pkg::SLOT_CR_WRITE] = 1'b1;
				end else if (fire_c) begin
					slot_vld[ubp_pkg::SLOT_FLUSH] = 1'b1;
					fill_nxt  = '0;
					flags_nxt = fl3;
				end else begin
					slots[ubp_pkg::SLOT_CR_WRITE] = ubp_pkg::RESULT_ACK;
					slot_vld[ubp_pkg::SLOT_CR_WRITE] = 1'b1;
				end
			end
			ubp_pkg::FUNC_DONE: begin
				flags_nxt.pending = flags.pending & ~done_mask;
				slots[ubp_pkg::SLOT_CR_WRITE] = ubp_pkg::RESULT_ACK;
				slot_vld[ubp_pkg::SLOT_CR_WRITE] = 1'b1;
			end
			default: begin
				// Configure reset
				fill_nxt  = '0;
				flags_nxt = '{cur_bank: 1'b0, flushed: 1'b1, pending: 2'b00};
				slots[ubp_pkg::SLOT_CR_WRITE] = ubp_pkg::RESULT_ACK;
				slot_vld[ubp_pkg::SLOT_CR_WRITE] = 1'b1;
			end
		endcase
	end

endmodule

// File: src/usb_bulk_in_double_buffer_packetizer.sv
// Timing: an item's first result word is offered in the cycle after the item moves out
// of the input register, so it passes the input register and then the slot register.
// Throughput: one item per cycle while each item yields one word and ready is high;
// a multi-word item (a newline: up to four) holds the slot register until all are taken.
// Reset (arst_n low): bank 0, fill 0, flushed set, no banks pending, link down,
// no words in flight.
// ----------------------------------------------------------------------------
// USB bulk IN double-buffer packetizer
// Input register, single-pass step logic, and a result slot register drained
// one word per handshake.
// ----------------------------------------------------------------------------
`include "usb_bulk_in_double_buffer_packetizer_macros.svh"

module usb_bulk_in_double_buffer_packetizer #(
	parameter int PACKET_SIZE = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic         cfg_data,
	ubp_item_if.sink     items,
	ubp_result_if.source results
);

	localparam int FW = $clog2(PACKET_SIZE);
	localparam int NS = ubp_pkg::NUM_SLOTS;

	// Input stage
	logic       vld_s1;
	logic [1:0] func_s1;
	logic [7:0] data_s1;
	logic [1:0] done_s1;

	// Bank state and link register
	logic [FW-1:0]   fill_q;
	ubp_pkg::flags_t flags_q;
	logic            link_q;

	// Step outputs
	logic [FW-1:0]              fill_nxt;
	ubp_pkg::flags_t            flags_nxt;
	logic [NS-1:0]              slot_vld_nxt;
	ubp_pkg::result_t [NS-1:0]  slots_nxt;

	// Result slot register and drain
	logic [NS-1:0]              slot_vld_q;
	ubp_pkg::result_t [NS-1:0]  slots_q;
	logic [NS-1:0]              sel_oh;
	logic [NS-1:0]              remaining;
	ubp_pkg::result_t           sel_res;
	logic                       take, slot_free, adv_s1;

	// Handshake control
	assign take      = results.valid & results.ready;
	assign remaining = slot_vld_q & ~sel_oh;
	assign slot_free = (slot_vld_q == '0) | (take & (remaining == '0));
	assign adv_s1    = vld_s1 & slot_free;
	assign items.ready = ~vld_s1 | adv_s1;

	// Hold the input word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (items.ready) begin
			vld_s1 <= items.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (items.valid && items.ready) begin
			func_s1 <= items.func;
			data_s1 <= items.data_byte;
			done_s1 <= items.done_mask;
		end
	end

	// Capture link state from the configuration port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q <= 1'b0;
		end else if (cfg_we) begin
			link_q <= cfg_data;
		end
	end

	ubp_step #(
		.PACKET_SIZE(PACKET_SIZE)
	) u_step (
		.link_up   (link_q),
		.func      (func_s1),
		.data_byte (data_s1),
		.done_mask (done_s1),
		.fill      (fill_q),
		.flags     (flags_q),
		.fill_nxt  (fill_nxt),
		.flags_nxt (flags_nxt),
		.slot_vld  (slot_vld_nxt),
		.slots     (slots_nxt)
	);

	// Advance bank state when the item moves to the slot register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			flags_q <= '{cur_bank: 1'b0, flushed: 1'b1, pending: 2'b00};
		end else if (adv_s1) begin
			fill_q  <= fill_nxt;
			flags_q <= flags_nxt;
		end
	end

	// Load or drain result slots
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_vld_q <= '0;
		end else if (adv_s1) begin
			slot_vld_q <= slot_vld_nxt;
		end else if (take) begin
			slot_vld_q <= remaining;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			slots_q <= slots_nxt;
		end
	end

	// Pick the lowest occupied slot
	always_comb begin
		sel_oh  = '0;
		sel_res = slots_q[0];
		for (int i = NS - 1; i >= 0; i--) begin
			if (slot_vld_q[i]) begin
				sel_oh  = NS'(1) << i;
				sel_res = slots_q[i];
			end
		end
	end

	assign results.valid    = |slot_vld_q;
	assign results.kind     = sel_res.kind;
	assign results.bank     = sel_res.bank;
	assign results.position = sel_res.position;
	assign results.out_byte = sel_res.out_byte;
	assign results.last     = remaining == '0;

	`UBP_ASSERT_NEXT(a_item_has_result, adv_s1, slot_vld_q != '0)
	`UBP_ASSERT_NEXT(a_slots_hold, !adv_s1 && !take, $stable(slot_vld_q))
	`UBP_ASSERT_NEXT(a_busy_keeps_state,
		adv_s1 && slot_vld_nxt[0] && slots_nxt[0].kind == ubp_pkg::KIND_BUSY,
		$stable(fill_q) && $stable(flags_q))
	`UBP_ASSERT_IMPL(a_fill_range, 1'b1, int'(fill_q) < PACKET_SIZE)

endmodule
